// ----- rtl/nsr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the named slot registry: sizes, codes, the slot record type
// and the name normalization function. Used by every other file in rtl.
package nsr_pkg;

  localparam int MAX_SLOTS  = 64;
  localparam int NAME_CHARS = 6;
  localparam int IDX_W      = $clog2(MAX_SLOTS);
  localparam int NAME_W     = NAME_CHARS * 8;
  localparam int NAME_IN_W  = 48;
  localparam int SLOT_W     = 6;
  localparam int FUNC_W     = 3;
  localparam int CNT_W      = 16;
  localparam int STATUS_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_RESERVE = 3'd0,
    FN_ATTACH  = 3'd1,
    FN_INC     = 3'd2,
    FN_DEC     = 3'd3,
    FN_FCLR    = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_APPLY,
    S_POST
  } state_t;

  // Contents of one slot as it travels around the ring.
  typedef struct packed {
    logic              reserved;
    logic [CNT_W-1:0]  count;
    logic [NAME_W-1:0] name;
  } slot_t;

  // Keep the low NAME_CHARS bytes and zero every byte from the first NUL on.
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_IN_W-1:0] raw);
    logic [63:0]       ext;
    logic [NAME_W-1:0] res;
    logic              stop;
    ext  = 64'(raw);
    res  = '0;
    stop = 1'b0;
    for (int b = 0; b < NAME_CHARS; b++) begin
      if (ext[8*b +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*b +: 8] = ext[8*b +: 8];
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/nsr_if.sv -----
`timescale 1ns / 1ps
// Request and result channel interfaces of the named slot registry.
// Depends on nsr_pkg for field widths.
interface nsr_in_if;
  logic                          valid;
  logic                          ready;
  logic [nsr_pkg::FUNC_W-1:0]    func;
  logic [nsr_pkg::NAME_IN_W-1:0] name;
  logic [nsr_pkg::SLOT_W-1:0]    slot;
  modport source (output valid, func, name, slot, input ready);
  modport sink (input valid, func, name, slot, output ready);
endinterface

interface nsr_out_if;
  logic                         valid;
  logic                         ready;
  logic [nsr_pkg::STATUS_W-1:0] status;
  logic [nsr_pkg::SLOT_W-1:0]   slot_out;
  logic [nsr_pkg::CNT_W-1:0]    ref_count;
  logic [nsr_pkg::SLOT_W-1:0]   top_index;
  modport source (output valid, status, slot_out, ref_count, top_index, input ready);
  modport sink (input valid, status, slot_out, ref_count, top_index, output ready);
endinterface

// ----- rtl/nsr_cell.sv -----
`timescale 1ns / 1ps
// One slot cell of the registry ring: holds a slot record and takes its
// neighbor's record on every shift. Depends on nsr_pkg.
module nsr_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  nsr_pkg::slot_t d_in,
  output nsr_pkg::slot_t q
);

  logic                      reserved_r;
  logic [nsr_pkg::CNT_W-1:0] count_r;
  logic [nsr_pkg::NAME_W-1:0] name_r;

  // Flag and count are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= 1'b0;
      count_r    <= '0;
    end else if (shift_en) begin
      reserved_r <= d_in.reserved;
      count_r    <= d_in.count;
    end
  end

  // The name holds whatever it was last given.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      name_r <= d_in.name;
    end
  end

  assign q = '{reserved: reserved_r, count: count_r, name: name_r};

endmodule

// ----- rtl/nsr_ring.sv -----
`timescale 1ns / 1ps
// Ring of slot cells: on each shift every cell takes its upper neighbor's
// record and the last cell takes tail_in. Depends on nsr_pkg, nsr_cell.
module nsr_ring (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  nsr_pkg::slot_t tail_in,
  output nsr_pkg::slot_t head
);

  nsr_pkg::slot_t cell_q [nsr_pkg::MAX_SLOTS];

  // Chain of cells, slot records moving toward cell 0.
  for (genvar i = 0; i < nsr_pkg::MAX_SLOTS; i++) begin : g_cell
    nsr_pkg::slot_t d;
    if (i == nsr_pkg::MAX_SLOTS - 1) begin : g_tail
      assign d = tail_in;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    nsr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (d),
      .q        (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

// ----- rtl/named_slot_registry.sv -----
`timescale 1ns / 1ps
// Named slot registry top level. One request at a time; a request passes
// from acceptance to result through a full rotation of the slot ring to
// search, a decision state, a second rotation to write back, and a state that
// loads the result register. The next request is accepted only after the last
// result is loaded, back in idle; a held result stalls it.
// Reset (synchronous, active low) clears every slot flag and count and the top index.
module named_slot_registry (
  input  logic clk,
  input  logic rst_n,
  nsr_in_if.sink    in_if,
  nsr_out_if.source out_if
);

  localparam logic [nsr_pkg::IDX_W-1:0] LAST_POS = nsr_pkg::IDX_W'(nsr_pkg::MAX_SLOTS - 1);
  localparam logic [nsr_pkg::CNT_W-1:0] CNT_MAX  = '1;

  nsr_pkg::state_t state_r, state_nxt;

  logic shift_en, in_ready, load_out, scan_clr;

  logic [nsr_pkg::IDX_W-1:0]  pos_r, pos_nxt;
  logic [nsr_pkg::IDX_W-1:0]  top_r, top_nxt;
  logic [nsr_pkg::FUNC_W-1:0] func_r;
  logic [nsr_pkg::NAME_W-1:0] nm_r;
  logic [nsr_pkg::SLOT_W-1:0] slot_r;

  // Search results gathered during the scan rotation.
  logic                       found_v_r;
  logic [nsr_pkg::IDX_W-1:0]  found_idx_r;
  logic [nsr_pkg::CNT_W-1:0]  found_cnt_r;
  logic                       free_v_r;
  logic [nsr_pkg::IDX_W-1:0]  free_idx_r;
  logic [nsr_pkg::CNT_W-1:0]  tcnt_r;
  logic [nsr_pkg::IDX_W-1:0]  maxu_r;

  // Decision held for the write-back rotation and the result.
  logic                          wr_en_r, wr_en_nxt;
  logic [nsr_pkg::IDX_W-1:0]     wr_idx_r, wr_idx_nxt;
  logic                          wr_res_r, wr_res_nxt;
  logic [nsr_pkg::CNT_W-1:0]     wr_cnt_r, wr_cnt_nxt;
  logic                          wr_name_r, wr_name_nxt;
  logic [nsr_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [nsr_pkg::IDX_W-1:0]     res_slot_r, res_slot_nxt;
  logic [nsr_pkg::CNT_W-1:0]     res_cnt_r, res_cnt_nxt;

  logic                          out_valid_r;
  logic [nsr_pkg::STATUS_W-1:0]  out_status_r;
  logic [nsr_pkg::SLOT_W-1:0]    out_slot_r;
  logic [nsr_pkg::CNT_W-1:0]     out_cnt_r;
  logic [nsr_pkg::SLOT_W-1:0]    out_top_r;

  nsr_pkg::slot_t head, tail_in;
  logic           head_used, head_hit, exclude;
  logic [nsr_pkg::IDX_W-1:0] slot_idx;
  logic           slot_ok, last_pos, out_free;
  logic [nsr_pkg::CNT_W-1:0] cnt_dec;

  assign slot_idx  = nsr_pkg::IDX_W'(slot_r);
  assign slot_ok   = int'(slot_r) < nsr_pkg::MAX_SLOTS;
  assign head_used = head.reserved || (head.count != '0);
  assign head_hit  = head_used && (head.name == nm_r);
  assign last_pos  = (pos_r == LAST_POS);
  assign out_free  = !out_valid_r || out_if.ready;

  // Slot ring; the write-back rewrites the target record on its way round.
  always_comb begin
    tail_in = head;
    if ((state_r == nsr_pkg::S_APPLY) && wr_en_r && (pos_r == wr_idx_r)) begin
      tail_in.reserved = wr_res_r;
      tail_in.count    = wr_cnt_r;
      if (wr_name_r) begin
        tail_in.name = nm_r;
      end
    end
  end

  nsr_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .tail_in  (tail_in),
    .head     (head)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nsr_pkg::S_IDLE:   if (in_if.valid) state_nxt = nsr_pkg::S_SCAN;
      nsr_pkg::S_SCAN:   if (last_pos) state_nxt = nsr_pkg::S_DECIDE;
      nsr_pkg::S_DECIDE: state_nxt = nsr_pkg::S_APPLY;
      nsr_pkg::S_APPLY:  if (last_pos) state_nxt = nsr_pkg::S_POST;
      nsr_pkg::S_POST:   if (out_free) state_nxt = nsr_pkg::S_IDLE;
      default:           state_nxt = nsr_pkg::S_IDLE;
    endcase
  end

  // State decoded controls.
  always_comb begin
    in_ready = 1'b0;
    shift_en = 1'b0;
    load_out = 1'b0;
    scan_clr = 1'b0;
    case (state_r)
      nsr_pkg::S_IDLE:  begin
        in_ready = 1'b1;
        scan_clr = 1'b1;
      end
      nsr_pkg::S_SCAN:  shift_en = 1'b1;
      nsr_pkg::S_APPLY: shift_en = 1'b1;
      nsr_pkg::S_POST:  load_out = out_free;
      default:          ;
    endcase
  end

  assign pos_nxt = shift_en ? (last_pos ? '0 : pos_r + 1'b1) : pos_r;

  // The record at the head is excluded from the top search if it is the target.
  always_comb begin
    exclude = 1'b0;
    if ((func_r == nsr_pkg::FN_DEC) && (pos_r == slot_idx)) begin
      exclude = 1'b1;
    end
    if ((func_r == nsr_pkg::FN_FCLR) && head_hit && !found_v_r) begin
      exclude = 1'b1;
    end
  end

  assign cnt_dec = (tcnt_r != '0) ? tcnt_r - 1'b1 : '0;

  // Decision on the gathered search results.
  always_comb begin
    wr_en_nxt      = 1'b0;
    wr_idx_nxt     = '0;
    wr_res_nxt     = 1'b0;
    wr_cnt_nxt     = '0;
    wr_name_nxt    = 1'b0;
    res_status_nxt = nsr_pkg::ST_OK;
    res_slot_nxt   = '0;
    res_cnt_nxt    = '0;
    top_nxt        = top_r;
    case (func_r)
      nsr_pkg::FN_RESERVE: begin
        if (found_v_r) begin
          res_status_nxt = nsr_pkg::ST_EXISTS;
          res_slot_nxt   = found_idx_r;
          res_cnt_nxt    = found_cnt_r;
        end else if (!free_v_r) begin
          res_status_nxt = nsr_pkg::ST_FULL;
        end else begin
          wr_en_nxt    = 1'b1;
          wr_idx_nxt   = free_idx_r;
          wr_res_nxt   = 1'b1;
          wr_name_nxt  = 1'b1;
          res_slot_nxt = free_idx_r;
          if (free_idx_r > top_r) begin
            top_nxt = free_idx_r;
          end
        end
      end
      nsr_pkg::FN_ATTACH: begin
        if (found_v_r) begin
          wr_en_nxt    = 1'b1;
          wr_idx_nxt   = found_idx_r;
          wr_cnt_nxt   = (found_cnt_r == CNT_MAX) ? found_cnt_r : found_cnt_r + 1'b1;
          res_slot_nxt = found_idx_r;
          res_cnt_nxt  = wr_cnt_nxt;
        end else begin
          res_status_nxt = nsr_pkg::ST_NOTFOUND;
        end
      end
      nsr_pkg::FN_INC: begin
        if (slot_ok) begin
          wr_en_nxt    = 1'b1;
          wr_idx_nxt   = slot_idx;
          wr_cnt_nxt   = (tcnt_r == CNT_MAX) ? tcnt_r : tcnt_r + 1'b1;
          res_slot_nxt = slot_idx;
          res_cnt_nxt  = wr_cnt_nxt;
          if (slot_idx > top_r) begin
            top_nxt = slot_idx;
          end
        end else begin
          res_status_nxt = nsr_pkg::ST_NOTFOUND;
        end
      end
      nsr_pkg::FN_DEC: begin
        if (slot_ok) begin
          wr_en_nxt    = 1'b1;
          wr_idx_nxt   = slot_idx;
          wr_cnt_nxt   = cnt_dec;
          res_slot_nxt = slot_idx;
          res_cnt_nxt  = cnt_dec;
          if ((cnt_dec == '0) && (slot_idx == top_r)) begin
            top_nxt = maxu_r;
          end
        end else begin
          res_status_nxt = nsr_pkg::ST_NOTFOUND;
        end
      end
      nsr_pkg::FN_FCLR: begin
        if (found_v_r) begin
          wr_en_nxt    = 1'b1;
          wr_idx_nxt   = found_idx_r;
          res_slot_nxt = found_idx_r;
          if (found_idx_r == top_r) begin
            top_nxt = maxu_r;
          end
        end else begin
          res_status_nxt = nsr_pkg::ST_NOTFOUND;
        end
      end
      default: res_status_nxt = nsr_pkg::ST_NOTFOUND;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsr_pkg::S_IDLE;
      pos_r       <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (state_r == nsr_pkg::S_DECIDE) begin
        top_r <= top_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture, search tracking and decision payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_if.valid) begin
      func_r <= in_if.func;
      nm_r   <= nsr_pkg::norm_name(in_if.name);
      slot_r <= in_if.slot;
    end
    if (scan_clr) begin
      found_v_r <= 1'b0;
      free_v_r  <= 1'b0;
      maxu_r    <= '0;
    end else if (state_r == nsr_pkg::S_SCAN) begin
      if (head_hit && !found_v_r) begin
        found_v_r   <= 1'b1;
        found_idx_r <= pos_r;
        found_cnt_r <= head.count;
      end
      if (!head_used && !free_v_r) begin
        free_v_r   <= 1'b1;
        free_idx_r <= pos_r;
      end
      if (pos_r == slot_idx) begin
        tcnt_r <= head.count;
      end
      if (head_used && !exclude) begin
        maxu_r <= pos_r;
      end
    end
    if (state_r == nsr_pkg::S_DECIDE) begin
      wr_en_r      <= wr_en_nxt;
      wr_idx_r     <= wr_idx_nxt;
      wr_res_r     <= wr_res_nxt;
      wr_cnt_r     <= wr_cnt_nxt;
      wr_name_r    <= wr_name_nxt;
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      res_cnt_r    <= res_cnt_nxt;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= nsr_pkg::SLOT_W'(res_slot_r);
      out_cnt_r    <= res_cnt_r;
      out_top_r    <= nsr_pkg::SLOT_W'(top_r);
    end
  end

  assign in_if.ready      = in_ready;
  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_status_r;
  assign out_if.slot_out  = out_slot_r;
  assign out_if.ref_count = out_cnt_r;
  assign out_if.top_index = out_top_r;

endmodule
